// ===== hdl/positional_list_engine_core_assert.svh =====
// Assertion macros used by the file that checks this block.
`ifndef POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional list engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional list engine check failed");

`endif

// ===== hdl/ple_pkg.sv =====
package ple_pkg;

  localparam int DEPTH = 16;
  localparam int WIDTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 5;
  localparam int OP_W = 3;
  localparam int ST_W = 2;
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  localparam logic [OP_W-1:0] OP_ADD_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_REAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd4;
  localparam logic [OP_W-1:0] OP_REM_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_OVER  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [31:0]      value;
  } in_beat_t;

  typedef struct packed {
    logic [31:0]      element;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] entries_now;
    logic             is_empty;
    logic             last;
  } out_beat_t;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             wrap;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] tail;
  } cell_ctrl_t;

endpackage

// ===== hdl/ple_cell.sv =====
module ple_cell (
  input  logic                    clk,
  input  logic [ple_pkg::IDX_W-1:0] cell_idx,
  input  ple_pkg::cell_ctrl_t     ctrl,
  input  logic [ple_pkg::WIDTH-1:0] fill,
  input  logic [ple_pkg::WIDTH-1:0] left_q,
  input  logic [ple_pkg::WIDTH-1:0] right_q,
  output logic [ple_pkg::WIDTH-1:0] data_q
);

  logic [ple_pkg::WIDTH-1:0] data_r;
  logic [ple_pkg::WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.wrap && (cell_idx == ctrl.tail)) begin
      data_nxt = fill;
    end else if (ctrl.ins && (cell_idx == ctrl.idx)) begin
      data_nxt = fill;
    end else if (ctrl.ins && (cell_idx > ctrl.idx)) begin
      data_nxt = left_q;
    end else if (ctrl.rem && (cell_idx >= ctrl.idx)) begin
      data_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// ===== hdl/positional_list_engine_core.sv =====
// Channel   Handshake          Payload
// request   start / busy       in_data  (ple_pkg::in_beat_t)
// result    out_valid strobe   out_data (ple_pkg::out_beat_t)
//
// An edit request shifts every cell in parallel; its result beat appears in
// the cycle after acceptance; busy stays low, so requests may come every cycle.
// During a dump of the n held elements, busy is high while the cells
// rotate the list past cell 0, one result beat per cycle.
// Reset clears the element count and the control state; the cells hold
// whatever was last written. The receiver cannot stall the result beats.
module positional_list_engine_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ple_pkg::in_beat_t  in_data,
  output logic               out_valid,
  output ple_pkg::out_beat_t out_data
);

  localparam int IDX_W = ple_pkg::IDX_W;
  localparam int CNT_W = ple_pkg::CNT_W;
  localparam int CMP_W = ple_pkg::CMP_W;
  localparam int WIDTH = ple_pkg::WIDTH;
  localparam int DEPTH = ple_pkg::DEPTH;

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  ple_pkg::out_beat_t out_data_r, out_data_nxt;

  ple_pkg::cell_ctrl_t ctrl;
  logic [WIDTH-1:0]    fill;
  logic [WIDTH-1:0]    slot_q [DEPTH];

  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] held_w;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] held_idx;
  logic [IDX_W-1:0] tail_idx;
  logic             full;
  logic             empty;
  logic             single;
  logic [31:0]      res_elem;
  logic [1:0]       res_st;
  logic             dump_last;

  assign pos_w    = CMP_W'(in_data.position);
  assign held_w   = CMP_W'(held_r);
  assign pos_idx  = IDX_W'(in_data.position - 1'b1);
  assign held_idx = held_r[IDX_W-1:0];
  assign tail_idx = IDX_W'(held_r - 1'b1);
  assign full     = (held_r == CNT_W'(DEPTH));
  assign empty    = (held_r == '0);
  assign dump_last = ((CNT_W'(cnt_r) + 1'b1) == held_r);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [WIDTH-1:0] left_d;
      logic [WIDTH-1:0] right_d;
      if (gi == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = slot_q[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_lastc
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = slot_q[gi+1];
      end
      ple_cell u_cell (
        .clk      (clk),
        .cell_idx (IDX_W'(gi)),
        .ctrl     (ctrl),
        .fill     (fill),
        .left_q   (left_d),
        .right_q  (right_d),
        .data_q   (slot_q[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ctrl          = '0;
    fill          = WIDTH'(in_data.value);
    single        = 1'b0;
    res_elem      = '0;
    res_st        = ple_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          single = 1'b1;
          case (in_data.operation)
            ple_pkg::OP_ADD_FRONT, ple_pkg::OP_ADD_REAR: begin
              if (full) begin
                res_st = ple_pkg::ST_OVER;
              end else begin
                ctrl.ins = 1'b1;
                ctrl.idx = (in_data.operation == ple_pkg::OP_ADD_FRONT) ? '0 : held_idx;
                held_nxt = held_r + 1'b1;
              end
            end
            ple_pkg::OP_REM_FRONT, ple_pkg::OP_REM_REAR: begin
              if (empty) begin
                res_st = ple_pkg::ST_UNDER;
              end else begin
                ctrl.rem = 1'b1;
                ctrl.idx = (in_data.operation == ple_pkg::OP_REM_FRONT) ? '0 : tail_idx;
                res_elem = 32'(slot_q[ctrl.idx]);
                held_nxt = held_r - 1'b1;
              end
            end
            ple_pkg::OP_INS_AT: begin
              if ((pos_w == '0) || (pos_w > held_w + 1'b1)) begin
                res_st = ple_pkg::ST_RANGE;
              end else if (full) begin
                res_st = ple_pkg::ST_OVER;
              end else begin
                ctrl.ins = 1'b1;
                ctrl.idx = pos_idx;
                held_nxt = held_r + 1'b1;
              end
            end
            ple_pkg::OP_REM_AT: begin
              if ((pos_w == '0) || (pos_w > held_w)) begin
                res_st = ple_pkg::ST_RANGE;
              end else begin
                ctrl.rem = 1'b1;
                ctrl.idx = pos_idx;
                res_elem = 32'(slot_q[ctrl.idx]);
                held_nxt = held_r - 1'b1;
              end
            end
            ple_pkg::OP_DUMP: begin
              if (!empty) begin
                single    = 1'b0;
                cnt_nxt   = '0;
                state_nxt = S_DUMP;
              end
            end
            default: begin
              res_st = ple_pkg::ST_RANGE;
            end
          endcase
          if (single) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.element     = res_elem;
            out_data_nxt.status      = res_st;
            out_data_nxt.entries_now = held_nxt;
            out_data_nxt.is_empty    = (held_nxt == '0);
            out_data_nxt.last        = 1'b1;
          end
        end
      end
      S_DUMP: begin
        ctrl.rem  = 1'b1;
        ctrl.wrap = 1'b1;
        ctrl.idx  = '0;
        ctrl.tail = tail_idx;
        fill      = slot_q[0];
        out_valid_nxt            = 1'b1;
        out_data_nxt.element     = 32'(slot_q[0]);
        out_data_nxt.status      = ple_pkg::ST_OK;
        out_data_nxt.entries_now = held_r;
        out_data_nxt.is_empty    = 1'b0;
        out_data_nxt.last        = dump_last;
        cnt_nxt = cnt_r + 1'b1;
        if (dump_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r == S_DUMP);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "positional_list_engine_core_assert.svh"

  `PLE_ASSERT_NOW(a_held_bound, 1'b1, held_r <= CNT_W'(DEPTH))
  `PLE_ASSERT_NEXT(a_dump_beats, state_r == S_DUMP, out_valid)
  `PLE_ASSERT_NEXT(a_edit_result, start && !busy && (in_data.operation != ple_pkg::OP_DUMP), out_valid && out_data.last)
  `PLE_ASSERT_NOW(a_last_frees, out_valid && out_data.last, !busy)

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ple_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 250;

  class deque_tracker;
    logic [WIDTH-1:0] cells[DEPTH];
    int held;
    out_beat_t expected_beats[$];
    int errors;

    function new();
      held = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void push_beat(logic [31:0] elem, logic [ST_W-1:0] st, logic fin);
      out_beat_t b;
      b.element = elem;
      b.status = st;
      b.entries_now = CNT_W'(held);
      b.is_empty = (held == 0);
      b.last = fin;
      expected_beats.push_back(b);
    endfunction

    function void insert_cell(int idx, logic [WIDTH-1:0] v);
      for (int i = held; i > idx; i--) cells[i] = cells[i-1];
      cells[idx] = v;
      held++;
    endfunction

    function logic [WIDTH-1:0] remove_cell(int idx);
      logic [WIDTH-1:0] v;
      v = cells[idx];
      for (int i = idx; i + 1 < held; i++) cells[i] = cells[i+1];
      held--;
      return v;
    endfunction

    function void note_request(in_beat_t req);
      logic [31:0] elem;
      logic [ST_W-1:0] st;
      int p;
      elem = '0;
      st = ST_OK;
      p = req.position;
      case (req.operation)
        OP_ADD_FRONT, OP_ADD_REAR: begin
          if (held >= DEPTH) st = ST_OVER;
          else insert_cell((req.operation == OP_ADD_FRONT) ? 0 : held, req.value);
        end
        OP_REM_FRONT, OP_REM_REAR: begin
          if (held == 0) st = ST_UNDER;
          else elem = remove_cell((req.operation == OP_REM_FRONT) ? 0 : held - 1);
        end
        OP_INS_AT: begin
          if (p < 1 || p > held + 1) st = ST_RANGE;
          else if (held >= DEPTH) st = ST_OVER;
          else insert_cell(p - 1, req.value);
        end
        OP_REM_AT: begin
          if (p < 1 || p > held) st = ST_RANGE;
          else elem = remove_cell(p - 1);
        end
        OP_DUMP: begin
          if (held == 0) begin
            push_beat('0, ST_OK, 1'b1);
          end else begin
            for (int i = 0; i < held; i++) push_beat(cells[i], ST_OK, i == held - 1);
          end
          return;
        end
        default: st = ST_RANGE;
      endcase
      push_beat(elem, st, 1'b1);
    endfunction

    task report(string msg);
      if (errors < 60) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_beat(out_beat_t got);
      out_beat_t want;
      if (expected_beats.size() == 0) begin
        report($sformatf("result beat with none expected: %p", got));
        return;
      end
      want = expected_beats.pop_front();
      if (got.element !== want.element)
        report($sformatf("element got %h want %h", got.element, want.element));
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.entries_now !== want.entries_now)
        report($sformatf("entries_now got %0d want %0d", got.entries_now,
                         want.entries_now));
      if (got.is_empty !== want.is_empty)
        report($sformatf("is_empty got %b want %b", got.is_empty, want.is_empty));
      if (got.last !== want.last)
        report($sformatf("last got %b want %b", got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_beat_t in_data;
  logic out_valid;
  out_beat_t out_data;

  deque_tracker list_track;
  int idle_cycles;

  positional_list_engine_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic in_beat_t make_req(logic [OP_W-1:0] op, int pos, logic [31:0] v);
    in_beat_t r;
    r.operation = op;
    r.position = POS_W'(pos);
    r.value = v;
    return r;
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_beat_t random_req(int fill_bias, int cnt);
    in_beat_t r;
    int pick;
    r.value = random_value();
    r.position = POS_W'($urandom_range(0, 17));
    pick = $urandom_range(99);
    if (pick == 99) begin
      r.operation = OP_UNUSED;
    end else if (pick < 8) begin
      r.operation = OP_DUMP;
    end else if (pick < 8 + fill_bias) begin
      case ($urandom_range(2))
        0: r.operation = OP_ADD_FRONT;
        1: r.operation = OP_ADD_REAR;
        default: begin
          r.operation = OP_INS_AT;
          if ($urandom_range(99) < 85) r.position = POS_W'($urandom_range(1, cnt + 1));
        end
      endcase
    end else begin
      case ($urandom_range(2))
        0: r.operation = OP_REM_FRONT;
        1: r.operation = OP_REM_REAR;
        default: begin
          r.operation = OP_REM_AT;
          if (cnt > 0 && $urandom_range(99) < 85)
            r.position = POS_W'($urandom_range(1, cnt));
        end
      endcase
    end
    return r;
  endfunction

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(in_beat_t req);
    start <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    list_track.note_request(req);
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      in_data <= $bits(in_beat_t)'({$urandom, $urandom});
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (list_track.pending() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) list_track.check_beat(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    in_beat_t directed[$];
    int fill_bias;
    bit steady;
    list_track = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_req(OP_DUMP, 1, '0));
    directed.push_back(make_req(OP_REM_FRONT, 1, '0));
    directed.push_back(make_req(OP_REM_REAR, 1, '0));
    directed.push_back(make_req(OP_REM_AT, 1, '0));
    directed.push_back(make_req(OP_INS_AT, 0, 32'h1111_1111));
    directed.push_back(make_req(OP_INS_AT, 2, 32'h2222_2222));
    directed.push_back(make_req(OP_INS_AT, 1, 32'hA5A5_5A5A));
    directed.push_back(make_req(OP_ADD_FRONT, 31, 32'hFFFF_FFFF));
    directed.push_back(make_req(OP_ADD_REAR, 0, 32'h0000_0000));
    directed.push_back(make_req(OP_INS_AT, 3, 32'h1234_5678));
    directed.push_back(make_req(OP_INS_AT, 5, 32'h8765_4321));
    directed.push_back(make_req(OP_REM_AT, 0, '0));
    directed.push_back(make_req(OP_REM_AT, 6, '0));
    directed.push_back(make_req(OP_REM_AT, 17, '0));
    directed.push_back(make_req(OP_INS_AT, 17, 32'h5555_AAAA));
    directed.push_back(make_req(OP_DUMP, 0, '1));
    directed.push_back(make_req(OP_REM_AT, 2, '0));
    directed.push_back(make_req(OP_REM_REAR, 16, '0));
    directed.push_back(make_req(OP_REM_FRONT, 15, '0));
    directed.push_back(make_req(OP_UNUSED, 8, 32'hDEAD_BEEF));
    directed.push_back(make_req(OP_DUMP, 1, '0));
    foreach (directed[i]) send_request(directed[i]);
    wait_drained();

    fill_bias = 80;
    steady = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0 && n > 0) begin
        wait_drained();
        case ((n / 50) % 4)
          0: fill_bias = 80;
          1: fill_bias = 15;
          2: fill_bias = 46;
          default: fill_bias = 70;
        endcase
      end
      if (n % 20 == 0) steady = ($urandom_range(99) < 30);
      send_request(random_req(fill_bias, list_track.held));
      if (!steady) hold_off(gap_length());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (list_track.errors == 0 && list_track.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine_core.sv
dv/tb_top.sv
